// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bitmap page allocator
// Request/response payloads, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PAGE_SHIFT = 12;   // 4096-byte pages
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned CFG_W      = 11;
  localparam logic [CFG_W-1:0] PAGE_WORDS_RST = 11'd1024;
  localparam logic [63:0] ALL_USED = {64{1'b1}};

  localparam logic [1:0] OP_ALLOC     = 2'd0;
  localparam logic [1:0] OP_FREE      = 2'd1;
  localparam logic [1:0] OP_MARK_FREE = 2'd2;
  localparam logic [1:0] OP_MARK_USED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [27:0] address;
    logic [15:0] base_page;
    logic [16:0] run_pages;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [27:0] page_address;
  } rsp_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_ALLOC = 6'b001000,
    S_MARK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

endpackage

// ===== hdl/bitmap_page_allocator_core.sv =====
`timescale 1ns / 1ps
// Sequence after accept: free S_RD, S_MARK, S_DONE; range mark S_RD and S_MARK
// per bitmap word touched, allocate S_RD and S_ALLOC per word scanned (one RAM
// port), both then S_DONE, which loads out_valid_o. Requests are taken only in
// S_IDLE; a busy output register holds the sequencer until out_ready_i frees it.
// Reset: a fill pass writes all ones into all MAP_WORDS bitmap words, one per
// cycle (1024 words at the default), before the first request is taken.
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core: bitmap page frame allocator
// One bit per 4 KiB page (set = used), kept in a single-port-style RAM and
// walked word by word by a small sequencer with one shared read-modify-write.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
  parameter int unsigned NUM_PAGES = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpa_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bpa_pkg::req_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bpa_pkg::rsp_t                out_data_o
);

  localparam int unsigned MAP_WORDS = (NUM_PAGES + 63) / 64;
  localparam int unsigned WIDX = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CW   = $clog2(MAP_WORDS + 1);
  localparam int unsigned LW   = (CW > bpa_pkg::CFG_W) ? CW : bpa_pkg::CFG_W;
  localparam int unsigned EW   = ($clog2(NUM_PAGES + 1) > 18) ? $clog2(NUM_PAGES + 1) : 18;
  localparam int unsigned PNW  = WIDX + 6;

  function automatic logic [5:0] ffz(input logic [63:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (!w[i]) r = 6'(i);
    end
    return r;
  endfunction

  bpa_pkg::state_e state_q, state_d;
  logic [CW-1:0]   word_q, word_d;
  logic [CW-1:0]   first_q, first_d;
  logic [CW-1:0]   last_q, last_d;
  logic [CW-1:0]   limit_q, limit_d;
  logic [5:0]      lo_q, lo_d;
  logic [5:0]      hi_q, hi_d;
  logic            set_q, set_d;
  logic [1:0]      status_q, status_d;
  logic [27:0]     paddr_q, paddr_d;
  logic            out_valid_q, out_valid_d;
  bpa_pkg::rsp_t   out_data_q, out_data_d;
  logic [bpa_pkg::CFG_W-1:0] page_words_q;
  // allocation vs. mark pass, latched at accept
  logic            alloc_mode_q;

  // bitmap RAM
  logic [63:0]     mem [0:MAP_WORDS-1];
  logic [63:0]     rdata_q;
  logic            mem_we, mem_re;
  logic [63:0]     mem_wdata;
  logic [WIDX-1:0] mem_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  // request decode
  logic [15:0]   free_page;
  logic [EW-1:0] rng_start, rng_end_raw, rng_end, rng_last;
  logic          rng_clip;
  logic [5:0]    ffz_bit;
  logic [5:0]    m_lo, m_hi;
  logic [63:0]   mark_mask;
  logic [PNW-1:0] alloc_page;
  logic          accept;

  assign accept      = in_valid_i && in_ready_o;
  assign free_page   = in_data_i.address[27:bpa_pkg::PAGE_SHIFT];
  assign rng_start   = EW'(in_data_i.base_page);
  assign rng_end_raw = rng_start + EW'(in_data_i.run_pages);
  assign rng_clip    = rng_end_raw > EW'(NUM_PAGES);
  assign rng_end     = rng_clip ? EW'(NUM_PAGES) : rng_end_raw;
  assign rng_last    = rng_end - EW'(1);

  assign ffz_bit    = ffz(rdata_q);
  assign alloc_page = {word_q[WIDX-1:0], ffz_bit};
  assign m_lo       = (word_q == first_q) ? lo_q : 6'd0;
  assign m_hi       = (word_q == last_q) ? hi_q : 6'd63;
  assign mark_mask  = (bpa_pkg::ALL_USED << m_lo) & (bpa_pkg::ALL_USED >> (6'd63 - m_hi));

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    first_d     = first_q;
    last_d      = last_q;
    limit_d     = limit_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    set_d       = set_q;
    status_d    = status_q;
    paddr_d     = paddr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = rdata_q;
    mem_addr    = word_q[WIDX-1:0];
    in_ready_o  = 1'b0;

    case (state_q)
      bpa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = bpa_pkg::ALL_USED;
        if (word_q == CW'(MAP_WORDS - 1)) begin
          word_d  = '0;
          state_d = bpa_pkg::S_IDLE;
        end else begin
          word_d = word_q + CW'(1);
        end
      end
      bpa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          status_d = bpa_pkg::ST_OK;
          paddr_d  = '0;
          case (in_data_i.operation)
            bpa_pkg::OP_ALLOC: begin
              word_d = '0;
              if (LW'(page_words_q) > LW'(MAP_WORDS)) limit_d = CW'(MAP_WORDS);
              else limit_d = CW'(page_words_q);
              if (page_words_q == '0) begin
                status_d = bpa_pkg::ST_NONE;
                state_d  = bpa_pkg::S_DONE;
              end else begin
                state_d = bpa_pkg::S_RD;
              end
            end
            bpa_pkg::OP_FREE: begin
              set_d = 1'b0;
              if (EW'(free_page) >= EW'(NUM_PAGES)) begin
                status_d = bpa_pkg::ST_LIMIT;
                state_d  = bpa_pkg::S_DONE;
              end else begin
                first_d = CW'(free_page >> 6);
                last_d  = CW'(free_page >> 6);
                word_d  = CW'(free_page >> 6);
                lo_d    = free_page[5:0];
                hi_d    = free_page[5:0];
                state_d = bpa_pkg::S_RD;
              end
            end
            default: begin
              // both range marks
              set_d = (in_data_i.operation == bpa_pkg::OP_MARK_USED);
              if (rng_clip) status_d = bpa_pkg::ST_LIMIT;
              if (rng_start >= rng_end) begin
                state_d = bpa_pkg::S_DONE;
              end else begin
                first_d = CW'(rng_start >> 6);
                word_d  = CW'(rng_start >> 6);
                last_d  = CW'(rng_last >> 6);
                lo_d    = rng_start[5:0];
                hi_d    = rng_last[5:0];
                state_d = bpa_pkg::S_RD;
              end
            end
          endcase
        end
      end
      bpa_pkg::S_RD: begin
        mem_re  = 1'b1;
        state_d = alloc_mode_q ? bpa_pkg::S_ALLOC : bpa_pkg::S_MARK;
      end
      bpa_pkg::S_ALLOC: begin
        if (rdata_q != bpa_pkg::ALL_USED) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | (64'd1 << ffz_bit);
          paddr_d   = 28'({alloc_page, {bpa_pkg::PAGE_SHIFT{1'b0}}});
          state_d   = bpa_pkg::S_DONE;
        end else if (word_q + CW'(1) == limit_q) begin
          status_d = bpa_pkg::ST_NONE;
          state_d  = bpa_pkg::S_DONE;
        end else begin
          word_d  = word_q + CW'(1);
          state_d = bpa_pkg::S_RD;
        end
      end
      bpa_pkg::S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = set_q ? (rdata_q | mark_mask) : (rdata_q & ~mark_mask);
        if (word_q == last_q) begin
          state_d = bpa_pkg::S_DONE;
        end else begin
          word_d  = word_q + CW'(1);
          state_d = bpa_pkg::S_RD;
        end
      end
      bpa_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = '{status: status_q, page_address: paddr_q};
          state_d     = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpa_pkg::S_CLEAR;
      word_q       <= '0;
      out_valid_q  <= 1'b0;
      page_words_q <= bpa_pkg::PAGE_WORDS_RST;
      alloc_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) page_words_q <= cfg_wdata_i;
      if (accept) alloc_mode_q <= (in_data_i.operation == bpa_pkg::OP_ALLOC);
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    last_q     <= last_d;
    limit_q    <= limit_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    set_q      <= set_d;
    status_q   <= status_d;
    paddr_q    <= paddr_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a failed or limited request never carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != bpa_pkg::ST_OK |-> out_data_o.page_address == '0)
    else $error("nonzero page address on non-ok status");

  // fill pass covers every word before the first request
  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == bpa_pkg::S_CLEAR) && state_q == bpa_pkg::S_IDLE
    |-> $past(word_q) == CW'(MAP_WORDS - 1))
    else $error("bitmap fill pass ended early");

  // scan pointer stays below the bound
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpa_pkg::S_ALLOC |-> word_q < limit_q)
    else $error("allocation scan past page_words");

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != bpa_pkg::S_IDLE)
    else $error("request accepted but sequencer idle");

endmodule
